// File: sv/lstp_pkg.sv
// shared types, constants and the cordic angle table for the lidar point filter
// no dependencies
`default_nettype none

package lstp_pkg;

    // fixed build constants
    localparam int LSTP_MAX_BEAMS     = 4096;
    localparam int LSTP_Y_OFFSET_MM   = 0;
    localparam int LSTP_CORDIC_STAGES = 16;
    localparam int LSTP_TABLE_LEN     = 24;
    localparam int LSTP_CW            = 34;
    localparam logic [15:0] LSTP_GAIN_Q16 = 16'd39797;

    // configuration register indexes
    localparam logic [2:0] LSTP_REG_ANGLE_START = 3'd0;
    localparam logic [2:0] LSTP_REG_ANGLE_STEP  = 3'd1;
    localparam logic [2:0] LSTP_REG_RANGE_LOW   = 3'd2;
    localparam logic [2:0] LSTP_REG_RANGE_HIGH  = 3'd3;
    localparam logic [2:0] LSTP_REG_SENSOR_X    = 3'd4;
    localparam logic [2:0] LSTP_REG_X_LOW       = 3'd5;
    localparam logic [2:0] LSTP_REG_X_HIGH      = 3'd6;
    localparam logic [2:0] LSTP_REG_Y_ABS_MAX   = 3'd7;

    typedef logic signed [LSTP_CW-1:0] t_cw;

    typedef struct packed {
        logic [11:0] beam_index;
        logic [15:0] range_mm;
        logic        range_finite;
        logic        last_beam;
    } t_in;

    typedef struct packed {
        logic              kept;
        logic signed [15:0] point_x_mm;
        logic signed [15:0] point_y_mm;
        logic [11:0]       beam_index_out;
        logic              last_beam_out;
    } t_out;

    typedef struct packed {
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] range_low_mm;
        logic [15:0] range_high_mm;
        logic [15:0] sensor_x_offset_mm;
        logic [15:0] x_low_mm;
        logic [15:0] x_high_mm;
        logic [14:0] y_abs_max_mm;
    } t_cfg;

    // per-request tag that rides alongside the rotation data
    typedef struct packed {
        logic        keep;
        logic        neg;
        logic [11:0] beam_index;
        logic        last_beam;
    } t_side;

    // atan(2^-i) in 2^32 units per turn
    function automatic t_cw f_atan(input int i);
        logic [31:0] v;
        begin
            unique case (i)
                0:  v = 32'h20000000;
                1:  v = 32'h12E4051E;
                2:  v = 32'h09FB385B;
                3:  v = 32'h051111D4;
                4:  v = 32'h028B0D43;
                5:  v = 32'h0145D7E1;
                6:  v = 32'h00A2F61E;
                7:  v = 32'h00517C55;
                8:  v = 32'h0028BE53;
                9:  v = 32'h00145F2F;
                10: v = 32'h000A2F98;
                11: v = 32'h000517CC;
                12: v = 32'h00028BE6;
                13: v = 32'h000145F3;
                14: v = 32'h0000A2FA;
                15: v = 32'h0000517D;
                16: v = 32'h000028BE;
                17: v = 32'h0000145F;
                18: v = 32'h00000A30;
                19: v = 32'h00000518;
                20: v = 32'h0000028C;
                21: v = 32'h00000146;
                22: v = 32'h000000A3;
                23: v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            return t_cw'(v);
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/lidar_scan_to_points_filter.sv
// lidar beam to obstacle point filter, cordic polar to cartesian, one request per cycle unless stalled
// stages: front a and b, CORDIC_STAGES rotations (capped at 24), back r, output register
// every stage has its own valid bit and takes a new request whenever it is empty or its
// successor moves, so bubbles are squeezed out
// reset: synchronous active low, clears all valid bits and loads the register defaults
`default_nettype none

module lidar_scan_to_points_filter #(
    parameter int CORDIC_STAGES = lstp_pkg::LSTP_CORDIC_STAGES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_addr,
    input  wire logic [15:0]    i_cfg_wdata,
    input  wire logic           i_valid,
    input  wire lstp_pkg::t_in  i_data,
    output logic                o_stall,
    output logic                o_valid,
    output lstp_pkg::t_out      o_data,
    input  wire logic           i_stall
);
    import lstp_pkg::*;

    localparam int NS = (CORDIC_STAGES < LSTP_TABLE_LEN) ? CORDIC_STAGES : LSTP_TABLE_LEN;

    t_cfg r_cfg;

    logic  w_v     [0:NS];
    logic  w_stall [0:NS];
    t_cw   w_x     [0:NS];
    t_cw   w_y     [0:NS];
    t_cw   w_z     [0:NS];
    t_side w_side  [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_start        <= 16'd0;
            r_cfg.angle_step         <= 16'd0;
            r_cfg.range_low_mm       <= 16'd200;
            r_cfg.range_high_mm      <= 16'd8000;
            r_cfg.sensor_x_offset_mm <= 16'd600;
            r_cfg.x_low_mm           <= 16'd400;
            r_cfg.x_high_mm          <= 16'd4000;
            r_cfg.y_abs_max_mm       <= 15'd3000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                LSTP_REG_ANGLE_START: r_cfg.angle_start        <= i_cfg_wdata;
                LSTP_REG_ANGLE_STEP:  r_cfg.angle_step         <= i_cfg_wdata;
                LSTP_REG_RANGE_LOW:   r_cfg.range_low_mm       <= i_cfg_wdata;
                LSTP_REG_RANGE_HIGH:  r_cfg.range_high_mm      <= i_cfg_wdata;
                LSTP_REG_SENSOR_X:    r_cfg.sensor_x_offset_mm <= i_cfg_wdata;
                LSTP_REG_X_LOW:       r_cfg.x_low_mm           <= i_cfg_wdata;
                LSTP_REG_X_HIGH:      r_cfg.x_high_mm          <= i_cfg_wdata;
                LSTP_REG_Y_ABS_MAX:   r_cfg.y_abs_max_mm       <= i_cfg_wdata[14:0];
            endcase
        end
    end

    lstp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (w_v[0]),
        .o_x     (w_x[0]),
        .o_y     (w_y[0]),
        .o_z     (w_z[0]),
        .o_side  (w_side[0]),
        .i_stall (w_stall[0])
    );

    for (genvar g = 0; g < NS; g++) begin : g_rot
        lstp_rot #(
            .SHIFT (g)
        ) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_side[g]),
            .o_stall (w_stall[g]),
            .o_valid (w_v[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_side[g+1]),
            .i_stall (w_stall[g+1])
        );
    end

    lstp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_v[NS]),
        .i_x     (w_x[NS]),
        .i_y     (w_y[NS]),
        .i_side  (w_side[NS]),
        .o_stall (w_stall[NS]),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // the residual angle after the last step is unused; fold it into a sanity check
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v[NS] && w_side[NS].keep) |-> (w_z[NS] < t_cw'(32'h20000000))
                                         && (w_z[NS] > -t_cw'(32'h20000000)))
        else $error("cordic residual angle out of range");

    // a kept point never carries an index outside the scan
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kept) |-> (32'(o_data.beam_index_out) < 32'(LSTP_MAX_BEAMS)))
        else $error("kept point with out of range beam index");

    // a rejected result carries a zero point
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.kept) |-> (o_data.point_x_mm == 16'sd0)
                                      && (o_data.point_y_mm == 16'sd0))
        else $error("rejected result with nonzero point");

endmodule

`default_nettype wire

// File: sv/lstp_front.sv
// front end: beam checks, beam angle, scaled range, quadrant fold into cordic start vector
// depends on lstp_pkg
`default_nettype none

module lstp_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lstp_pkg::t_cfg i_cfg,
    input  wire logic          i_valid,
    input  wire lstp_pkg::t_in i_data,
    output logic               o_stall,
    output logic               o_valid,
    output lstp_pkg::t_cw      o_x,
    output lstp_pkg::t_cw      o_y,
    output lstp_pkg::t_cw      o_z,
    output lstp_pkg::t_side    o_side,
    input  wire logic          i_stall
);
    import lstp_pkg::*;

    // stage a: checks and the two products
    logic        r_a_v;
    t_side       r_a_side;
    logic [15:0] r_a_ang;
    logic [31:0] r_a_prod;
    logic        a_en;

    // stage b: folded angle and start vector
    logic        r_b_v;
    t_side       r_b_side;
    t_cw         r_b_x;
    t_cw         r_b_z;
    logic        b_en;

    logic [27:0] w_idx_prod;
    logic [15:0] n_a_ang;
    logic [31:0] n_a_prod;
    logic        w_in_ok;
    t_side       n_a_side;

    logic signed [16:0] w_a;
    logic signed [16:0] w_z16;
    logic               w_neg;
    t_side              n_b_side;

    assign b_en    = !r_b_v || !i_stall;
    assign a_en    = !r_a_v || b_en;
    assign o_stall = !a_en;

    always_comb begin
        w_idx_prod = i_data.beam_index * i_cfg.angle_step;
        n_a_ang    = i_cfg.angle_start + w_idx_prod[15:0];
        n_a_prod   = i_data.range_mm * LSTP_GAIN_Q16;
        w_in_ok    = (32'(i_data.beam_index) < 32'(LSTP_MAX_BEAMS)) && i_data.range_finite
                     && (i_data.range_mm >= i_cfg.range_low_mm)
                     && (i_data.range_mm <= i_cfg.range_high_mm);
        n_a_side.keep       = w_in_ok;
        n_a_side.neg        = 1'b0;
        n_a_side.beam_index = i_data.beam_index;
        n_a_side.last_beam  = i_data.last_beam;
    end

    // fold the angle into the right half plane, negate the vector at the end
    always_comb begin
        w_a   = {r_a_ang[15], r_a_ang};
        w_z16 = w_a;
        w_neg = 1'b0;
        priority if (w_a > 17'sd16384) begin
            w_z16 = w_a - 17'sd32768;
            w_neg = 1'b1;
        end else if (w_a < -17'sd16384) begin
            w_z16 = w_a + 17'sd32768;
            w_neg = 1'b1;
        end
        n_b_side     = r_a_side;
        n_b_side.neg = w_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_a_v <= i_valid;
            end
            if (b_en) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_a_side <= n_a_side;
            r_a_ang  <= n_a_ang;
            r_a_prod <= n_a_prod;
        end
        if (b_en && r_a_v) begin
            r_b_side <= n_b_side;
            r_b_x    <= t_cw'(r_a_prod[31:2]);
            r_b_z    <= t_cw'(w_z16) <<< 16;
        end
    end

    assign o_valid = r_b_v;
    assign o_x     = r_b_x;
    assign o_y     = '0;
    assign o_z     = r_b_z;
    assign o_side  = r_b_side;

    // a non-finite request never reaches stage a marked as kept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_data.range_finite) |=> !(r_a_v && r_a_side.keep))
        else $error("non-finite range marked as kept");

    // an empty range window always rejects
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_cfg.range_low_mm > i_cfg.range_high_mm))
        |=> !r_a_side.keep)
        else $error("empty range window passed a request");

endmodule

`default_nettype wire

// File: sv/lstp_rot.sv
// one registered cordic rotation step with its own valid and stall
// depends on lstp_pkg
`default_nettype none

module lstp_rot #(
    parameter int SHIFT = 0
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire lstp_pkg::t_cw  i_x,
    input  wire lstp_pkg::t_cw  i_y,
    input  wire lstp_pkg::t_cw  i_z,
    input  wire lstp_pkg::t_side i_side,
    output logic                o_stall,
    output logic                o_valid,
    output lstp_pkg::t_cw       o_x,
    output lstp_pkg::t_cw       o_y,
    output lstp_pkg::t_cw       o_z,
    output lstp_pkg::t_side     o_side,
    input  wire logic           i_stall
);
    import lstp_pkg::*;

    localparam t_cw Atan = f_atan(SHIFT);

    logic  r_v;
    t_cw   r_x;
    t_cw   r_y;
    t_cw   r_z;
    t_side r_side;
    t_cw   w_xs;
    t_cw   w_ys;
    t_cw   n_x;
    t_cw   n_y;
    t_cw   n_z;

    assign o_stall = r_v && i_stall;

    always_comb begin
        w_xs = i_x >>> SHIFT;
        w_ys = i_y >>> SHIFT;
        if (!i_z[LSTP_CW-1]) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - Atan;
        end else begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (!o_stall) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// File: sv/lstp_back.sv
// back end: sign fix and rounding to millimetres, offsets, window tests, output register
// depends on lstp_pkg
`default_nettype none

module lstp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lstp_pkg::t_cfg  i_cfg,
    input  wire logic            i_valid,
    input  wire lstp_pkg::t_cw   i_x,
    input  wire lstp_pkg::t_cw   i_y,
    input  wire lstp_pkg::t_side i_side,
    output logic                 o_stall,
    output logic                 o_valid,
    output lstp_pkg::t_out       o_data,
    input  wire logic            i_stall
);
    import lstp_pkg::*;

    localparam int RW = LSTP_CW - 14;
    localparam int PW = RW + 1;

    // stage r: rounded cos and sin terms
    logic                 r_r_v;
    t_side                r_r_side;
    logic signed [RW-1:0] r_c;
    logic signed [RW-1:0] r_s;
    logic                 r_en;

    // output register
    logic r_o_v;
    t_out r_o_data;

    t_cw w_xn;
    t_cw w_yn;
    t_cw w_xr;
    t_cw w_yr;

    logic signed [PW-1:0] w_px;
    logic signed [PW-1:0] w_py;
    logic signed [PW-1:0] w_ay;
    logic                 w_keep;
    t_out                 n_o_data;

    assign r_en    = !r_o_v || !i_stall;
    assign o_stall = r_r_v && !r_en;

    always_comb begin
        w_xn = i_side.neg ? -i_x : i_x;
        w_yn = i_side.neg ? -i_y : i_y;
        w_xr = w_xn + t_cw'(8192);
        w_yr = w_yn + t_cw'(8192);
    end

    always_comb begin
        w_px   = PW'($signed(i_cfg.sensor_x_offset_mm)) + PW'(r_c);
        w_py   = PW'(LSTP_Y_OFFSET_MM) + PW'(r_s);
        w_ay   = w_py[PW-1] ? -w_py : w_py;
        w_keep = r_r_side.keep
                 && (w_px >= PW'($signed(i_cfg.x_low_mm)))
                 && (w_px <= PW'($signed(i_cfg.x_high_mm)))
                 && (w_ay <= $signed(PW'(i_cfg.y_abs_max_mm)));
        n_o_data.kept           = w_keep;
        n_o_data.point_x_mm     = w_keep ? w_px[15:0] : 16'sd0;
        n_o_data.point_y_mm     = w_keep ? w_py[15:0] : 16'sd0;
        n_o_data.beam_index_out = r_r_side.beam_index;
        n_o_data.last_beam_out  = r_r_side.last_beam;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_r_v <= i_valid;
            end
            if (r_en) begin
                r_o_v <= r_r_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_r_side <= i_side;
            r_c      <= w_xr[LSTP_CW-1:14];
            r_s      <= w_yr[LSTP_CW-1:14];
        end
        if (r_en && r_r_v) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_data;

    // a rejected request leaves the output stage with cleared coordinates
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_en && r_r_v && !r_r_side.keep) |=> (!r_o_data.kept && r_o_data.point_x_mm == 16'sd0
                                               && r_o_data.point_y_mm == 16'sd0))
        else $error("rejected request left a point behind");

endmodule

`default_nettype wire
